/* sv/mpre_pkg.sv */
package mpre_pkg;

    // Register file geometry
    localparam int unsigned PHY_REG_COUNT_DEF = 32;
    localparam int unsigned DATA_W            = 16;
    localparam int unsigned ADDR_W            = 5;
    localparam int unsigned FUNC_W            = 2;
    localparam logic [ADDR_W-1:0] OWN_ADDR_RST = 5'd1;

    // Operation codes
    localparam logic [FUNC_W-1:0] OP_WRITE = 2'd1;
    localparam logic [FUNC_W-1:0] OP_READ  = 2'd2;

    // Clause 22 register indexes
    localparam logic [4:0] IDX_CTRL   = 5'd0;
    localparam logic [4:0] IDX_STAT   = 5'd1;
    localparam logic [4:0] IDX_ID1    = 5'd2;
    localparam logic [4:0] IDX_ID2    = 5'd3;
    localparam logic [4:0] IDX_ADV    = 5'd4;
    localparam logic [4:0] IDX_LPA    = 5'd5;
    localparam logic [4:0] IDX_CTRL1G = 5'd9;
    localparam logic [4:0] IDX_STAT1G = 5'd10;
    localparam logic [4:0] IDX_ESTAT  = 5'd15;

    // Control and status bit positions
    localparam int unsigned CTRL_RESET_BIT     = 15;
    localparam int unsigned CTRL_PDOWN_BIT     = 11;
    localparam int unsigned CTRL_ISOLATE_BIT   = 10;
    localparam int unsigned CTRL_ANRESTART_BIT = 9;
    localparam int unsigned STAT_LINK_BIT      = 2;
    localparam int unsigned STAT_ANDONE_BIT    = 5;

    localparam logic [DATA_W-1:0] CTRL_DEFAULT  = 16'h1140;
    localparam logic [DATA_W-1:0] MISMATCH_DATA = 16'hFFFF;

    // Power-on value of each register
    function automatic logic [DATA_W-1:0] reg_default(input logic [4:0] idx);
        logic [DATA_W-1:0] v;
        case (idx)
            IDX_CTRL:   v = CTRL_DEFAULT;
            IDX_STAT:   v = 16'h7929;
            IDX_ID1:    v = 16'h600D;
            IDX_ID2:    v = 16'h84A2;
            IDX_ADV:    v = 16'h0DE1;
            IDX_LPA:    v = 16'h4DE1;
            IDX_CTRL1G: v = 16'h0200;
            IDX_STAT1G: v = 16'h3800;
            IDX_ESTAT:  v = 16'h3000;
            default:    v = '0;
        endcase
        return v;
    endfunction

    // Registers that ignore writes
    function automatic logic reg_read_only(input logic [4:0] idx);
        logic ro;
        case (idx)
            IDX_STAT, IDX_ID1, IDX_ID2, IDX_STAT1G, IDX_ESTAT: ro = 1'b1;
            default:                                           ro = 1'b0;
        endcase
        return ro;
    endfunction

endpackage

/* sv/mdio_phy_register_engine_core.sv */
// Channel   Direction  Handshake            Payload
// command   in         i_valid / o_ready    i_func, i_phy_select, i_reg_index,
//                                           i_write_data, i_line_link_up
// result    out        o_valid / i_ready    o_data_out, o_read_fail, o_done_irq,
//                                           o_error_irq, o_link_status
// config    in         i_cfg_we (no wait)   i_cfg_wdata (own PHY address)
//
// One command per cycle unless the result stalls: the register file is read and
// updated in the cycle the beat is accepted, and the result lands in the output
// register on that edge, visible in the cycle after acceptance.
// A new command is taken while the output register is empty or being drained.
// Reset (synchronous, active low) marks every register entry as holding its
// default and sets the own address to 1; a control write with the reset bit
// does the same to the entries.
module mdio_phy_register_engine_core
    import mpre_pkg::*;
#(
    parameter int unsigned PHY_REG_COUNT = PHY_REG_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [ADDR_W-1:0] i_cfg_wdata,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [FUNC_W-1:0] i_func,
    input  logic [ADDR_W-1:0] i_phy_select,
    input  logic [ADDR_W-1:0] i_reg_index,
    input  logic [DATA_W-1:0] i_write_data,
    input  logic              i_line_link_up,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [DATA_W-1:0] o_data_out,
    output logic              o_read_fail,
    output logic              o_done_irq,
    output logic              o_error_irq,
    output logic              o_link_status
);

    localparam int unsigned IDX_W = $clog2(PHY_REG_COUNT);

    // Register file: entries read their default until first written
    logic [DATA_W-1:0]        r_file [PHY_REG_COUNT];
    logic [PHY_REG_COUNT-1:0] r_entry_valid;
    logic [ADDR_W-1:0]        r_own_addr;

    logic              r_out_valid;
    logic [DATA_W-1:0] r_data_out;
    logic              r_fail;
    logic              r_link;

    logic              accept;
    logic [IDX_W-1:0]  idx;
    logic [4:0]        idx5;
    logic              addr_hit;
    logic              is_read;
    logic              is_write;
    logic [DATA_W-1:0] entry_rd;
    logic [DATA_W-1:0] ctrl_cur;
    logic [DATA_W-1:0] ctrl_nxt;
    logic              do_ctrl_reset;
    logic              do_ctrl_store;
    logic              do_plain_store;
    logic              link_cur;
    logic              link_nxt;
    logic [DATA_W-1:0] n_data_out;
    logic              n_fail;

    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;

    // Decode the command
    assign idx      = i_reg_index[IDX_W-1:0];
    assign idx5     = ADDR_W'(idx);
    assign addr_hit = (i_phy_select == r_own_addr);
    assign is_read  = addr_hit && (i_func == OP_READ);
    assign is_write = addr_hit && (i_func == OP_WRITE);

    assign do_ctrl_reset  = is_write && (idx5 == IDX_CTRL) && i_write_data[CTRL_RESET_BIT];
    assign do_ctrl_store  = is_write && (idx5 == IDX_CTRL) && !i_write_data[CTRL_RESET_BIT];
    assign do_plain_store = is_write && (idx5 != IDX_CTRL) && !reg_read_only(idx5);

    // Read the addressed entry and the control register
    assign entry_rd = r_entry_valid[idx] ? r_file[idx] : reg_default(idx5);
    assign ctrl_cur = r_entry_valid[0] ? r_file[0] : CTRL_DEFAULT;

    // Control value after this command takes effect
    always_comb begin
        ctrl_nxt = ctrl_cur;
        if (do_ctrl_reset) begin
            ctrl_nxt = CTRL_DEFAULT;
        end else if (do_ctrl_store) begin
            ctrl_nxt = i_write_data;
            ctrl_nxt[CTRL_ANRESTART_BIT] = 1'b0;
        end
    end

    assign link_cur = i_line_link_up && !ctrl_cur[CTRL_PDOWN_BIT]
                      && !ctrl_cur[CTRL_ISOLATE_BIT];
    assign link_nxt = i_line_link_up && !ctrl_nxt[CTRL_PDOWN_BIT]
                      && !ctrl_nxt[CTRL_ISOLATE_BIT];

    // Form the result word
    always_comb begin
        n_data_out = i_write_data;
        n_fail     = 1'b0;
        if (!addr_hit) begin
            n_data_out = MISMATCH_DATA;
            n_fail     = 1'b1;
        end else if (is_read) begin
            n_data_out = entry_rd;
            if (idx5 == IDX_STAT) begin
                n_data_out[STAT_LINK_BIT]   = link_cur;
                n_data_out[STAT_ANDONE_BIT] = link_cur;
            end
        end else if (!is_write) begin
            n_fail = 1'b1;
        end
    end

    // Update the register file contents
    always_ff @(posedge i_clk) begin
        if (accept && do_ctrl_store) begin
            r_file[0] <= ctrl_nxt;
        end else if (accept && do_plain_store) begin
            r_file[idx] <= i_write_data;
        end
    end

    // Track which entries hold written data; own address register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_valid <= '0;
            r_own_addr    <= OWN_ADDR_RST;
        end else begin
            if (i_cfg_we) begin
                r_own_addr <= i_cfg_wdata;
            end
            if (accept && do_ctrl_reset) begin
                r_entry_valid <= '0;
            end else if (accept && do_ctrl_store) begin
                r_entry_valid[0] <= 1'b1;
            end else if (accept && do_plain_store) begin
                r_entry_valid[idx] <= 1'b1;
            end
        end
    end

    // Hold the result beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data_out <= n_data_out;
            r_fail     <= n_fail;
            r_link     <= link_nxt;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_data_out    = r_data_out;
    assign o_read_fail   = r_fail;
    assign o_done_irq    = 1'b1;
    assign o_error_irq   = r_fail;
    assign o_link_status = r_link;

    // A defaults reload leaves no written entry behind
    a_reload_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && do_ctrl_reset |=> r_entry_valid == '0)
        else $error("register reload left written entries");

    // An accepted command always yields a result beat
    a_accept_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_valid)
        else $error("accepted command produced no result");

    // A command for another PHY fails with all-ones data
    a_mismatch_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !addr_hit |=> o_data_out == MISMATCH_DATA && o_read_fail)
        else $error("address mismatch result wrong");

    // A powered-down or isolated PHY never reports link on a new result
    a_link_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (ctrl_nxt[CTRL_PDOWN_BIT] || ctrl_nxt[CTRL_ISOLATE_BIT])
        |=> !o_link_status)
        else $error("link reported while PHY is down or isolated");

endmodule
